// File: hdl/prwa_pkg.sv
// Shared types and constants for the peer registry with aging.
package prwa_pkg;

  // Index and count fields are sized for the largest supported table (256 entries).
  localparam int IDX_W = 8;
  localparam int CNT_W = 9;
  localparam logic [15:0] PERIOD_RESET = 16'd60;

  typedef enum logic [2:0] {
    ST_UPDATED = 3'd0,
    ST_ADDED   = 3'd1,
    ST_FULL    = 3'd2,
    ST_IGNORED = 3'd3,
    ST_TICK    = 3'd4
  } status_t;

  typedef enum logic {
    OP_HEARTBEAT = 1'b0,
    OP_TICK      = 1'b1
  } op_t;

  typedef struct packed {
    op_t         operation;
    logic        fields_valid;
    logic [15:0] peer_port;
    logic [9:0]  interval_minutes;
  } in_item_t;

  typedef struct packed {
    status_t    status;
    logic [3:0] slot;
    logic [4:0] removed_count;
    logic [4:0] live_count;
  } out_item_t;

  // Scan token handed from cell to cell, one cell per cycle.
  typedef struct packed {
    logic             active;
    logic             sweep;
    logic [15:0]      port;
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic             free;
    logic [IDX_W-1:0] free_idx;
    logic [CNT_W-1:0] removed;
  } token_t;

  // Write broadcast to the cells at the end of a lookup.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic [15:0]      port;
    logic [31:0]      deadline;
  } entry_wr_t;

endpackage

// File: hdl/prwa_cell.sv
// One table entry of the registry chain: storage, match and expiry check.
module prwa_cell #(
  parameter int CELL_INDEX = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [31:0]        now,
  input  prwa_pkg::entry_wr_t wr,
  input  prwa_pkg::token_t   tok_in,
  output prwa_pkg::token_t   tok_out
);
  import prwa_pkg::*;

  logic        valid;
  logic [15:0] port;
  logic [31:0] deadline;
  logic [31:0] age;
  logic        expired;
  logic        wr_here;
  token_t      tok_next;

  // The entry has expired when now lies strictly after its deadline, wrap-safe.
  assign age     = now - deadline;
  assign expired = valid && (age != 32'd0) && !age[31];
  assign wr_here = wr.en && (wr.idx == IDX_W'(CELL_INDEX));

  always_comb begin
    tok_next = tok_in;
    if (tok_in.active) begin
      if (tok_in.sweep) begin
        if (expired) begin
          tok_next.removed = tok_in.removed + CNT_W'(1);
        end
      end else if (valid) begin
        if (!tok_in.hit && (port == tok_in.port)) begin
          tok_next.hit     = 1'b1;
          tok_next.hit_idx = IDX_W'(CELL_INDEX);
        end
      end else if (!tok_in.free) begin
        tok_next.free     = 1'b1;
        tok_next.free_idx = IDX_W'(CELL_INDEX);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid          <= 1'b0;
      tok_out.active <= 1'b0;
    end else begin
      tok_out <= tok_next;
      if (wr_here) begin
        valid <= 1'b1;
      end else if (tok_in.active && tok_in.sweep && expired) begin
        valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_here) begin
      port     <= wr.port;
      deadline <= wr.deadline;
    end
  end

endmodule

// File: hdl/peer_registry_with_aging.sv
// Top level of the peer registry with aging: control, seconds clock and cell chain.
// An invalid heartbeat or a tick without a sweep goes from acceptance straight to the
// result hold; a lookup or a sweep walks a token down the chain of TABLE_ENTRIES cells,
// one cell per cycle, and reaches the result hold when the token leaves the last cell.
// Throughput: one item at a time; the next is taken once the result reaches the output
// register. Synchronous reset empties the table, zeroes the clock and loads period 60.
module peer_registry_with_aging #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [15:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  prwa_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output prwa_pkg::out_item_t  out_item
);
  import prwa_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_HOLD
  } state_t;

  state_t           state;
  logic [15:0]      period;
  logic [15:0]      to_sweep;
  logic [31:0]      clock_seconds;
  logic [CNT_W-1:0] live;
  logic [16:0]      span;
  out_item_t        res;
  token_t           tok_head;
  token_t           tok [TABLE_ENTRIES+1];
  entry_wr_t        wr;

  logic             accept;
  logic             out_free;
  logic             scan_done;
  logic [10:0]      span_base;
  logic [15:0]      reload;
  token_t           end_tok;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != S_IDLE);
  assign out_free  = !out_valid || !out_stall;
  assign tok[0]    = tok_head;
  assign end_tok   = tok[TABLE_ENTRIES];
  assign scan_done = (state == S_SCAN) && end_tok.active;

  // The lifetime of an entry is (2*interval + 1) minutes; times 60 is 64x - 4x.
  assign span_base = {in_item.interval_minutes, 1'b1};
  assign reload    = (period == 16'd0) ? 16'd1 : period;

  // At the end of a lookup, refresh the hit entry or claim the lowest free slot.
  // The deadline is the current clock plus the stored lifetime.
  always_comb begin
    wr.en       = scan_done && !end_tok.sweep && (end_tok.hit || end_tok.free);
    wr.idx      = end_tok.hit ? end_tok.hit_idx : end_tok.free_idx;
    wr.port     = end_tok.port;
    wr.deadline = clock_seconds + 32'(span);
  end

  // The chain of cells. Each cell registers the token before passing it on, and the token
  // leaves the last cell carrying the match, free slot and removal count.
  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    prwa_cell #(
      .CELL_INDEX(i)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .now    (clock_seconds),
      .wr     (wr),
      .tok_in (tok[i]),
      .tok_out(tok[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      period          <= PERIOD_RESET;
      to_sweep        <= PERIOD_RESET;
      clock_seconds   <= 32'd0;
      live            <= '0;
      out_valid       <= 1'b0;
      tok_head.active <= 1'b0;
    end else begin
      // A new period only matters at the next reload of the countdown.
      if (cfg_we) begin
        period <= cfg_data;
      end

      // The output register loads the pending result once it is free, and
      // otherwise empties when its item is taken.
      if ((state == S_HOLD) && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            tok_head.port     <= in_item.peer_port;
            tok_head.hit      <= 1'b0;
            tok_head.hit_idx  <= '0;
            tok_head.free     <= 1'b0;
            tok_head.free_idx <= '0;
            tok_head.removed  <= '0;
            res.slot          <= 4'd0;
            res.removed_count <= 5'd0;
            res.live_count    <= live[4:0];
            if (in_item.operation == OP_TICK) begin
              clock_seconds <= clock_seconds + 32'd1;
              res.status    <= ST_TICK;
              if (to_sweep <= 16'd1) begin
                // The sweep sees the already advanced clock.
                to_sweep        <= reload;
                tok_head.active <= 1'b1;
                tok_head.sweep  <= 1'b1;
                state           <= S_SCAN;
              end else begin
                to_sweep        <= to_sweep - 16'd1;
                tok_head.active <= 1'b0;
                tok_head.sweep  <= 1'b0;
                state           <= S_HOLD;
              end
            end else if (!in_item.fields_valid) begin
              res.status      <= ST_IGNORED;
              tok_head.active <= 1'b0;
              tok_head.sweep  <= 1'b0;
              state           <= S_HOLD;
            end else begin
              span            <= 17'({span_base, 6'b0}) - 17'({span_base, 2'b0});
              tok_head.active <= 1'b1;
              tok_head.sweep  <= 1'b0;
              state           <= S_SCAN;
            end
          end else begin
            tok_head.active <= 1'b0;
          end
        end
        S_SCAN: begin
          tok_head.active <= 1'b0;
          if (scan_done) begin
            state <= S_HOLD;
            if (end_tok.sweep) begin
              live              <= live - end_tok.removed;
              res.removed_count <= end_tok.removed[4:0];
              res.live_count    <= 5'(live - end_tok.removed);
            end else if (end_tok.hit) begin
              res.status <= ST_UPDATED;
              res.slot   <= end_tok.hit_idx[3:0];
            end else if (end_tok.free) begin
              live           <= live + CNT_W'(1);
              res.status     <= ST_ADDED;
              res.slot       <= end_tok.free_idx[3:0];
              res.live_count <= 5'(live + CNT_W'(1));
            end else begin
              res.status <= ST_FULL;
            end
          end
        end
        S_HOLD: begin
          tok_head.active <= 1'b0;
          if (out_free) begin
            out_item <= res;
            state    <= S_IDLE;
          end
        end
        default: begin
          tok_head.active <= 1'b0;
          state           <= S_IDLE;
        end
      endcase
    end
  end

  // The table never holds more live entries than it has cells.
  a_live_bound: assert property (@(posedge clk) disable iff (rst)
    live <= CNT_W'(TABLE_ENTRIES))
    else $error("live count exceeds table size");

  // A token only leaves the chain while a scan is in progress.
  a_token_in_scan: assert property (@(posedge clk) disable iff (rst)
    end_tok.active |-> (state == S_SCAN))
    else $error("token left the chain outside a scan");

  // Entries are written only at the end of a lookup, never during a sweep.
  a_write_lookup: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> (scan_done && !end_tok.sweep))
    else $error("entry write outside a finished lookup");

  // Every scan finishes into a pending result on the following cycle.
  a_scan_to_hold: assert property (@(posedge clk) disable iff (rst)
    scan_done |=> (state == S_HOLD))
    else $error("finished scan did not produce a result");

endmodule
